>>> sv/snc_pkg.sv
package snc_pkg;

	localparam int MassWidth   = 16;
	localparam int CfgIdxWidth = 8;
	localparam int CfgWidth    = 16;
	localparam int CountWidth  = 11;
	localparam int CountMax    = 2047;
	localparam int DefMaxAtoms = 1024;
	localparam int DivSteps    = 33;
	localparam int DivCntWidth = 6;

	localparam logic [CfgIdxWidth-1:0] RegLambda   = 8'd0;
	localparam logic [CfgIdxWidth-1:0] RegZeroBand = 8'd1;

	localparam logic [CfgWidth-1:0] LambdaReset   = 16'd0;
	localparam logic [CfgWidth-1:0] ZeroBandReset = 16'd1;

	typedef struct packed {
		logic load;
		logic skip_clr;
		logic mul;
		logic eval;
		logic div_step;
		logic wb;
		logic finish;
	} snc_cmd_t;

	typedef struct packed {
		logic skip_pending;
		logic in_band;
		logic rd_zero;
		logic div_last;
		logic last;
		logic out_free;
	} snc_status_t;

endpackage

>>> sv/sturm_negative_count.sv
// Flow: an item with a full pivot passes multiply, evaluate, the 33-step radix-2
// reciprocal divider and write-back before in_ready returns; a pivot in the zero band
// or an exact zero pivot skips the divider, and a skipped item goes straight to finish.
// The result of a last item is valid the cycle after it ends; one item at a time.
// Reset: arst_n clears chain state, handshakes and sets lambda_value to 0, zero_band to 1.
module sturm_negative_count
	import snc_pkg::*;
#(
	parameter int MAX_ATOMS = DefMaxAtoms
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [MassWidth-1:0]   mass_ratio,
	input  logic                   last,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [CountWidth-1:0]  negative_count,
	output logic                   saturated,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CfgIdxWidth-1:0] cfg_index,
	input  logic [CfgWidth-1:0]    cfg_data
);

	snc_cmd_t    cmd;
	snc_status_t st;

	assign cfg_ready = 1'b1;

	snc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	snc_datapath #(
		.MAX_ATOMS (MAX_ATOMS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mass_ratio     (mass_ratio),
		.last           (last),
		.cmd            (cmd),
		.st             (st),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.negative_count (negative_count),
		.saturated      (saturated)
	);

endmodule

>>> sv/snc_ctrl.sv
module snc_ctrl
	import snc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  snc_status_t st,
	output snc_cmd_t    cmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MUL  = 6'b000010,
		S_EVAL = 6'b000100,
		S_DIV  = 6'b001000,
		S_WB   = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (st.skip_pending) begin
						cmd.skip_clr = 1'b1;
						state_d      = S_FIN;
					end else begin
						state_d = S_MUL;
					end
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				if (st.in_band || st.rd_zero) begin
					state_d = S_FIN;
				end else begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					state_d = S_WB;
				end
			end
			S_WB: begin
				cmd.wb  = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!st.last) begin
					state_d = S_IDLE;
				end else if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> sv/snc_datapath.sv
module snc_datapath
	import snc_pkg::*;
#(
	parameter int MAX_ATOMS = DefMaxAtoms
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic [CfgIdxWidth-1:0] cfg_index,
	input  logic [CfgWidth-1:0]    cfg_data,
	input  logic [MassWidth-1:0]   mass_ratio,
	input  logic                   last,
	input  snc_cmd_t               cmd,
	output snc_status_t            st,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [CountWidth-1:0]  negative_count,
	output logic                   saturated
);

	localparam int CountCap = (MAX_ATOMS < CountMax) ? MAX_ATOMS : CountMax;

	logic [CfgWidth-1:0]    lambda_q, zero_band_q;
	logic [MassWidth-1:0]   mass_q;
	logic                   last_q;
	logic [31:0]            prod_q;
	logic [31:0]            r_q;
	logic                   skip_q;
	logic [CountWidth-1:0]  count_q;
	logic                   sat_q;
	logic [31:0]            div_d_q;
	logic                   neg_q;
	logic [31:0]            rem_q;
	logic [32:0]            quo_q;
	logic [DivCntWidth-1:0] cnt_q;
	logic                   out_valid_q;
	logic [CountWidth-1:0]  out_count_q;
	logic                   out_sat_q;

	logic signed [34:0] rd_full;
	logic        [31:0] rd_c;
	logic               rd_clip;
	logic               rd_neg;
	logic        [31:0] rd_mag;
	logic               in_band;
	logic               rd_zero;
	logic               bump_ok;
	logic        [32:0] shifted;
	logic               q_bit;
	logic        [31:0] rem_next;
	logic        [31:0] q_res;
	logic               q_clip;

	always_comb begin
		rd_full = $signed(35'h0_0002_0000)
			- $signed({11'b0, prod_q[31:8]})
			- $signed({{3{r_q[31]}}, r_q});
		rd_clip = 1'b0;
		rd_c    = rd_full[31:0];
		if (rd_full > $signed(35'h0_7FFF_FFFF)) begin
			rd_c    = 32'h7FFF_FFFF;
			rd_clip = 1'b1;
		end else if (rd_full < $signed(35'h7_8000_0000)) begin
			rd_c    = 32'h8000_0000;
			rd_clip = 1'b1;
		end
		rd_neg  = rd_c[31];
		rd_mag  = rd_neg ? (~rd_c + 32'd1) : rd_c;
		in_band = rd_mag < {16'b0, zero_band_q};
		rd_zero = (rd_c == 32'd0);
		bump_ok = count_q < CountWidth'(CountCap);
	end

	always_comb begin
		shifted  = {rem_q, (cnt_q == DivCntWidth'(DivSteps - 1))};
		q_bit    = shifted >= {1'b0, div_d_q};
		rem_next = q_bit ? 32'(shifted - {1'b0, div_d_q}) : shifted[31:0];
	end

	always_comb begin
		q_clip = 1'b0;
		if (!neg_q) begin
			q_res = quo_q[31:0];
			if (quo_q > 33'h0_7FFF_FFFF) begin
				q_res  = 32'h7FFF_FFFF;
				q_clip = 1'b1;
			end
		end else begin
			q_res = ~quo_q[31:0] + 32'd1;
			if (quo_q > 33'h0_8000_0000) begin
				q_res  = 32'h8000_0000;
				q_clip = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lambda_q    <= LambdaReset;
			zero_band_q <= ZeroBandReset;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				RegLambda:   lambda_q    <= cfg_data;
				RegZeroBand: zero_band_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q         <= '0;
			skip_q      <= 1'b0;
			count_q     <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.skip_clr) begin
				skip_q <= 1'b0;
			end
			if (cmd.eval) begin
				if (rd_clip) begin
					sat_q <= 1'b1;
				end
				if ((in_band || rd_neg) && bump_ok) begin
					count_q <= count_q + 1'b1;
				end
				if (in_band) begin
					r_q    <= '0;
					skip_q <= 1'b1;
				end else if (rd_zero) begin
					r_q   <= 32'h7FFF_FFFF;
					sat_q <= 1'b1;
				end
			end
			if (cmd.wb) begin
				r_q <= q_res;
				if (q_clip) begin
					sat_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				r_q         <= '0;
				skip_q      <= 1'b0;
				count_q     <= '0;
				sat_q       <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mass_q <= mass_ratio;
			last_q <= last;
		end
		if (cmd.mul) begin
			prod_q <= 32'(mass_q) * 32'(lambda_q);
		end
		if (cmd.eval) begin
			div_d_q <= rd_mag;
			neg_q   <= rd_neg;
			rem_q   <= '0;
			quo_q   <= '0;
			cnt_q   <= DivCntWidth'(DivSteps - 1);
		end
		if (cmd.div_step) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[31:0], q_bit};
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.finish) begin
			out_count_q <= count_q;
			out_sat_q   <= sat_q;
		end
	end

	assign st.skip_pending = skip_q;
	assign st.in_band      = in_band;
	assign st.rd_zero      = rd_zero;
	assign st.div_last     = (cnt_q == '0);
	assign st.last         = last_q;
	assign st.out_free     = !out_valid_q || out_ready;

	assign out_valid      = out_valid_q;
	assign negative_count = out_count_q;
	assign saturated      = out_sat_q;

endmodule

>>> sv/snc_checker.sv
module snc_checker
	import snc_pkg::*;
#(
	parameter int MAX_ATOMS = DefMaxAtoms
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  last,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [CountWidth-1:0] negative_count,
	input logic                  saturated
);

	localparam int CountCap = (MAX_ATOMS < CountMax) ? MAX_ATOMS : CountMax;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(negative_count) && $stable(saturated))
		else $error("result changed while stalled");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> negative_count <= CountWidth'(CountCap))
		else $error("count above cap");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction while busy");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !last |=> !$rose(out_valid))
		else $error("result without last transaction");

endmodule

bind sturm_negative_count snc_checker #(
	.MAX_ATOMS (MAX_ATOMS)
) u_snc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.last           (last),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.negative_count (negative_count),
	.saturated      (saturated)
);

>>> tb/sv/pivot_count_checker.sv
module pivot_count_checker
	import snc_pkg::*;
#(
	parameter int MAX_ATOMS = DefMaxAtoms
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [MassWidth-1:0]   mass_ratio,
	input  logic                   last,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [CountWidth-1:0]  negative_count,
	input  logic                   saturated,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CfgIdxWidth-1:0] cfg_index,
	input  logic [CfgWidth-1:0]    cfg_data,
	output int                     mismatches,
	output int                     outstanding
);

	typedef struct packed {
		logic [CountWidth-1:0] count;
		logic                  sat;
	} chain_result_t;

	localparam longint PivotMax = 64'sd2147483647;
	localparam longint PivotMin = -64'sd2147483648;
	localparam longint TwoQ16   = 64'sd131072;
	localparam longint OneQ32   = 64'sd4294967296;
	localparam int     CountCap = (MAX_ATOMS < CountMax) ? MAX_ATOMS : CountMax;

	logic [CfgWidth-1:0]   lambda_q;
	logic [CfgWidth-1:0]   band_q;
	logic signed [31:0]    recip;
	logic                  skip_next;
	logic [CountWidth-1:0] neg_pivots;
	logic                  clipped;
	chain_result_t         count_queue[$];

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	function automatic void clear_chain();
		recip = '0;
		skip_next = 1'b0;
		neg_pivots = '0;
		clipped = 1'b0;
	endfunction

	function automatic void bump_count();
		if (neg_pivots < CountCap) neg_pivots++;
	endfunction

	function automatic longint clamp_pivot(input longint v);
		if (v > PivotMax) begin
			clipped = 1'b1;
			return PivotMax;
		end
		if (v < PivotMin) begin
			clipped = 1'b1;
			return PivotMin;
		end
		return v;
	endfunction

	function automatic bit sturm_step(input logic [MassWidth-1:0] mass, input logic is_last,
			output chain_result_t res);
		longint prod;
		longint rd;
		longint mag;
		longint q;
		if (skip_next) begin
			skip_next = 1'b0;
		end else begin
			prod = (longint'(mass) * longint'(lambda_q)) >> 8;
			rd = clamp_pivot(TwoQ16 - prod - longint'(recip));
			mag = (rd < 0) ? -rd : rd;
			if (mag < longint'(band_q)) begin
				bump_count();
				recip = '0;
				skip_next = 1'b1;
			end else begin
				if (rd < 0) bump_count();
				if (rd == 0) begin
					clipped = 1'b1;
					q = PivotMax;
				end else begin
					q = clamp_pivot(OneQ32 / rd);
				end
				recip = q[31:0];
			end
		end
		res.count = neg_pivots;
		res.sat = clipped;
		if (is_last) begin
			clear_chain();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		chain_result_t want;
		chain_result_t got;
		if (!arst_n) begin
			lambda_q = LambdaReset;
			band_q = ZeroBandReset;
			clear_chain();
			count_queue.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == RegLambda) lambda_q = cfg_data;
				else if (cfg_index == RegZeroBand) band_q = cfg_data;
			end
			if (out_valid && out_ready) begin
				if (count_queue.size() == 0) begin
					report_mismatch("result with no chain pending", negative_count, 0);
				end else begin
					want = count_queue.pop_front();
					got.count = negative_count;
					got.sat = saturated;
					if (got.count !== want.count)
						report_mismatch("negative_count", got.count, want.count);
					if (got.sat !== want.sat)
						report_mismatch("saturated", got.sat, want.sat);
				end
			end
			if (in_valid && in_ready) begin
				if (sturm_step(mass_ratio, last, want)) count_queue.push_back(want);
			end
		end
		outstanding = count_queue.size();
	end

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
	import snc_pkg::*;

	localparam logic [CfgIdxWidth-1:0] RegUnused = 8'hFF;
	localparam int SettleCycles = 48;
	localparam int LongChain = 40;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [MassWidth-1:0]   mass_ratio = '0;
	logic                   last = 1'b0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [CountWidth-1:0]  negative_count;
	logic                   saturated;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CfgIdxWidth-1:0] cfg_index = RegLambda;
	logic [CfgWidth-1:0]    cfg_data = '0;

	int send_idle = 16;
	int recv_idle = 49;
	int mismatches;
	int outstanding;

	always #6 clk = ~clk;

	sturm_negative_count dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mass_ratio     (mass_ratio),
		.last           (last),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.negative_count (negative_count),
		.saturated      (saturated),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	pivot_count_checker count_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mass_ratio     (mass_ratio),
		.last           (last),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.negative_count (negative_count),
		.saturated      (saturated),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatches     (mismatches),
		.outstanding    (outstanding)
	);

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	initial begin
		#(12 * 600000);
		$display("Mismatches found");
		$finish;
	end

	// hold the transaction until accepted; valid stays up for a back-to-back follower
	task automatic send_atom(input logic [MassWidth-1:0] mass, input logic is_last);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mass_ratio <= mass;
		last <= is_last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_reg(input logic [CfgIdxWidth-1:0] idx, input logic [CfgWidth-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic configure(input logic [CfgWidth-1:0] lam, input logic [CfgWidth-1:0] band);
		set_reg(RegLambda, lam);
		set_reg(RegZeroBand, band);
		cfg_valid <= 1'b0;
	endtask

	// drop valid, wait for every pending result, then let the divider finish
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	function automatic logic [MassWidth-1:0] pick_mass();
		case ($urandom_range(3))
			0: return MassWidth'($urandom_range(0, 16'h0400));
			1: return MassWidth'($urandom_range(0, 16'h4000));
			2: return MassWidth'($urandom_range(16'h1FC0, 16'h2040));
			default: return MassWidth'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	function automatic logic [CfgWidth-1:0] pick_lambda();
		case ($urandom_range(3))
			0: return CfgWidth'($urandom_range(0, 16'h0400));
			1: return CfgWidth'($urandom_range(0, 16'h2000));
			2: return 16'h1000;
			default: return CfgWidth'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	function automatic logic [CfgWidth-1:0] pick_band();
		case ($urandom_range(4))
			0: return 16'h0000;
			1: return 16'h0001;
			2: return CfgWidth'($urandom_range(0, 16'h0100));
			3: return 16'hFFFF;
			default: return CfgWidth'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	task automatic random_chains(input int atoms);
		int left;
		int len;
		left = atoms;
		while (left > 0) begin
			len = $urandom_range(1, 20);
			if (len > left) len = left;
			for (int i = 0; i < len; i++) send_atom(pick_mass(), i == len - 1);
			left -= len;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_atom(16'h0000, 1'b0);
		send_atom(16'hFFFF, 1'b1);
		settle();

		// zero pivot inside the band, skipped atoms, zero pivot on the last atom
		set_reg(RegUnused, 16'hA5A5);
		configure(16'h1000, 16'h0001);
		send_atom(16'h2000, 1'b1);
		send_atom(16'h2000, 1'b0);
		send_atom(16'hFFFF, 1'b0);
		send_atom(16'h0000, 1'b1);
		send_atom(16'h2000, 1'b0);
		send_atom(16'h1234, 1'b1);
		settle();

		// exact zero pivot with an empty band
		configure(16'h1000, 16'h0000);
		send_atom(16'h2000, 1'b0);
		send_atom(16'h0000, 1'b1);
		settle();

		// pivot of -1 clips the reciprocal, then the sum clips
		configure(16'd768, 16'h0000);
		send_atom(16'd43691, 1'b0);
		send_atom(16'h0000, 1'b1);
		settle();

		// pivot of +1 clips the reciprocal
		configure(16'd601, 16'h0000);
		send_atom(16'd55831, 1'b1);
		settle();

		configure(16'hFFFF, 16'hFFFF);
		send_atom(16'hFFFF, 1'b0);
		send_atom(16'h0000, 1'b0);
		send_atom(16'hFFFF, 1'b1);
		settle();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 16 : (phase == 1) ? 49 : 0;
			recv_idle = (phase == 0) ? 49 : (phase == 1) ? 16 : 0;
			for (int seg = 0; seg < 6; seg++) begin
				configure(pick_lambda(), pick_band());
				random_chains(28);
				settle();
			end
		end

		// every pivot negative
		configure(16'hFFFF, 16'h0000);
		for (int i = 0; i < LongChain; i++)
			send_atom(MassWidth'(16'h8000 | $urandom_range(0, 16'h7FFF)), i == LongChain - 1);
		settle();

		if (mismatches == 0 && outstanding == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

>>> files.f
sv/snc_pkg.sv
sv/snc_ctrl.sv
sv/snc_datapath.sv
sv/sturm_negative_count.sv
sv/snc_checker.sv
tb/sv/pivot_count_checker.sv
tb/sv/tb_top.sv
